// ----- hdl/szl_pkg.sv -----
// Shared types, constants and codes of the sample zone lookup block.
package szl_pkg;

  localparam int MAX_ZONES  = 16;
  localparam int NOTE_COUNT = 128;
  localparam int IDX_W      = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int CNT_W      = $clog2(MAX_ZONES + 1);
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int BOUND_W    = 8;
  localparam int DIST_W     = $clog2(NOTE_COUNT + 1);
  localparam int FQ_DEPTH   = 2;
  localparam int OUT_IDX_W  = 4;

  // Input opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // Configuration register indexes
  localparam logic REG_MAP_MODE = 1'b0;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_CLEAR,
    KIND_LOOKUP,
    KIND_NOP
  } kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_SCAN_BEST,
    BK_SCAN_PICK,
    BK_RESULT
  } bk_state_t;

  typedef struct packed {
    kind_t                     kind;
    logic [NOTE_W-1:0]         note;
    logic [VEL_W-1:0]          velocity;
    logic [NOTE_W-1:0]         root_note;
    logic [NOTE_W-1:0]         low_note;
    logic [NOTE_W-1:0]         high_note;
    logic signed [BOUND_W-1:0] low_velocity;
    logic signed [BOUND_W-1:0] high_velocity;
  } req_t;

  typedef struct packed {
    logic [NOTE_W-1:0]         root;
    logic [NOTE_W-1:0]         note_lo;
    logic [NOTE_W-1:0]         note_hi;
    logic signed [BOUND_W-1:0] vel_lo;
    logic signed [BOUND_W-1:0] vel_hi;
  } zone_t;

  typedef struct packed {
    logic found;
    logic [OUT_IDX_W-1:0] zone_index;
    logic [1:0] status;
  } result_t;

endpackage

// ----- hdl/szl_front.sv -----
// Front end: accept requests, classify the opcode, queue them for the back end.
module szl_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [szl_pkg::NOTE_W-1:0] in_note,
  input  logic [szl_pkg::VEL_W-1:0]  in_velocity,
  input  logic [szl_pkg::NOTE_W-1:0] in_root_note,
  input  logic [szl_pkg::NOTE_W-1:0] in_low_note,
  input  logic [szl_pkg::NOTE_W-1:0] in_high_note,
  input  logic signed [szl_pkg::BOUND_W-1:0] in_low_velocity,
  input  logic signed [szl_pkg::BOUND_W-1:0] in_high_velocity,
  output logic                       q_valid,
  input  logic                       q_pop,
  output szl_pkg::req_t              q_req
);

  localparam int PTR_W = (szl_pkg::FQ_DEPTH > 1) ? $clog2(szl_pkg::FQ_DEPTH) : 1;
  localparam int QCNT_W = $clog2(szl_pkg::FQ_DEPTH + 1);

  szl_pkg::req_t     queue_r [szl_pkg::FQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  szl_pkg::req_t     new_req;

  // Classify the opcode; the unused code becomes a no-op request.
  always_comb begin
    new_req.note          = in_note;
    new_req.velocity      = in_velocity;
    new_req.root_note     = in_root_note;
    new_req.low_note      = in_low_note;
    new_req.high_note     = in_high_note;
    new_req.low_velocity  = in_low_velocity;
    new_req.high_velocity = in_high_velocity;
    case (in_opcode)
      szl_pkg::OP_LOAD:   new_req.kind = szl_pkg::KIND_LOAD;
      szl_pkg::OP_CLEAR:  new_req.kind = szl_pkg::KIND_CLEAR;
      szl_pkg::OP_LOOKUP: new_req.kind = szl_pkg::KIND_LOOKUP;
      default:            new_req.kind = szl_pkg::KIND_NOP;
    endcase
  end

  assign in_stall = (cnt_r == QCNT_W'(szl_pkg::FQ_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_req    = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(szl_pkg::FQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(szl_pkg::FQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_req;
    end
  end

endmodule

// ----- hdl/szl_back.sv -----
// Back end: zone table, lookup scanner and result register.
module szl_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          map_mode,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  szl_pkg::req_t                 q_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [szl_pkg::OUT_IDX_W-1:0] out_zone_index,
  output logic [1:0]                    out_status
);

  localparam int IDX_W  = szl_pkg::IDX_W;
  localparam int CNT_W  = szl_pkg::CNT_W;
  localparam int DIST_W = szl_pkg::DIST_W;
  localparam int OIW    = szl_pkg::OUT_IDX_W;

  szl_pkg::zone_t     zone_mem [szl_pkg::MAX_ZONES];
  szl_pkg::zone_t     rdata_r;
  szl_pkg::bk_state_t state_r, state_nxt;
  szl_pkg::req_t      cur_r, cur_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   addr_r, addr_nxt;
  logic               rvalid_r, rvalid_nxt;
  logic [IDX_W-1:0]   ridx_r, ridx_nxt;
  logic [DIST_W-1:0]  best_r, best_nxt;
  logic [1:0]         cands_r, cands_nxt;
  logic [IDX_W-1:0]   only_r, only_nxt;
  logic               pick_found_r, pick_found_nxt;
  logic [IDX_W-1:0]   pick_r, pick_nxt;
  szl_pkg::result_t   res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  szl_pkg::result_t   out_r;
  logic               out_load;
  logic               mem_we, mem_re;
  szl_pkg::zone_t     wdata;
  logic [DIST_W-1:0]  root_gap;
  logic               note_hit, vel_ok, cand;
  logic               scan_done;

  assign wdata.root    = cur_r.root_note;
  assign wdata.note_lo = cur_r.low_note;
  assign wdata.note_hi = cur_r.high_note;
  assign wdata.vel_lo  = cur_r.low_velocity;
  assign wdata.vel_hi  = cur_r.high_velocity;

  // Per-entry tests on the registered read data.
  always_comb begin
    if (rdata_r.root > cur_r.note) begin
      root_gap = DIST_W'(rdata_r.root - cur_r.note);
    end else begin
      root_gap = DIST_W'(cur_r.note - rdata_r.root);
    end
    note_hit = (cur_r.note >= rdata_r.note_lo) && (cur_r.note <= rdata_r.note_hi);
    vel_ok   = rdata_r.vel_lo[szl_pkg::BOUND_W-1] || rdata_r.vel_hi[szl_pkg::BOUND_W-1] ||
               ((cur_r.velocity >= rdata_r.vel_lo[szl_pkg::VEL_W-1:0]) &&
                (cur_r.velocity <= rdata_r.vel_hi[szl_pkg::VEL_W-1:0]));
    cand     = map_mode ? (root_gap == best_r) : note_hit;
  end

  assign scan_done = (addr_r == count_r) && !rvalid_r;

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    count_nxt      = count_r;
    addr_nxt       = addr_r;
    rvalid_nxt     = 1'b0;
    ridx_nxt       = ridx_r;
    best_nxt       = best_r;
    cands_nxt      = cands_r;
    only_nxt       = only_r;
    pick_found_nxt = pick_found_r;
    pick_nxt       = pick_r;
    res_nxt        = res_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    out_load       = 1'b0;

    // Issue the next table read while a scan is in progress.
    if ((state_r inside {szl_pkg::BK_SCAN_BEST, szl_pkg::BK_SCAN_PICK}) &&
        addr_r != count_r) begin
      mem_re     = 1'b1;
      addr_nxt   = addr_r + 1'b1;
      rvalid_nxt = 1'b1;
      ridx_nxt   = addr_r[IDX_W-1:0];
    end

    case (state_r)
      szl_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_req;
          state_nxt = szl_pkg::BK_EXEC;
        end
      end
      szl_pkg::BK_EXEC: begin
        res_nxt   = '{found: 1'b0, zone_index: '0, status: szl_pkg::ST_OK};
        state_nxt = szl_pkg::BK_RESULT;
        case (cur_r.kind)
          szl_pkg::KIND_LOAD: begin
            if (count_r < CNT_W'(szl_pkg::MAX_ZONES)) begin
              mem_we             = 1'b1;
              count_nxt          = count_r + 1'b1;
              res_nxt.zone_index = OIW'(count_r);
            end else begin
              res_nxt.status = szl_pkg::ST_FULL;
            end
          end
          szl_pkg::KIND_CLEAR: begin
            count_nxt = '0;
          end
          szl_pkg::KIND_LOOKUP: begin
            addr_nxt       = '0;
            best_nxt       = DIST_W'(szl_pkg::NOTE_COUNT);
            cands_nxt      = '0;
            pick_found_nxt = 1'b0;
            state_nxt      = map_mode ? szl_pkg::BK_SCAN_BEST : szl_pkg::BK_SCAN_PICK;
          end
          default: ;
        endcase
      end
      szl_pkg::BK_SCAN_BEST: begin
        if (rvalid_r && root_gap < best_r) begin
          best_nxt = root_gap;
        end
        if (scan_done) begin
          addr_nxt  = '0;
          state_nxt = szl_pkg::BK_SCAN_PICK;
        end
      end
      szl_pkg::BK_SCAN_PICK: begin
        if (rvalid_r && cand) begin
          if (cands_r != 2'd2) begin
            cands_nxt = cands_r + 1'b1;
          end
          only_nxt = ridx_r;
          if (!pick_found_r && vel_ok) begin
            pick_found_nxt = 1'b1;
            pick_nxt       = ridx_r;
          end
        end
        if (scan_done) begin
          state_nxt = szl_pkg::BK_RESULT;
          if (cands_r == 2'd1) begin
            res_nxt = '{found: 1'b1, zone_index: OIW'(only_r), status: szl_pkg::ST_OK};
          end else if (pick_found_r) begin
            res_nxt = '{found: 1'b1, zone_index: OIW'(pick_r), status: szl_pkg::ST_OK};
          end else begin
            res_nxt = '{found: 1'b0, zone_index: '0, status: szl_pkg::ST_NONE};
          end
        end
      end
      szl_pkg::BK_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = szl_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = szl_pkg::BK_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= szl_pkg::BK_IDLE;
      count_r     <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    addr_r       <= addr_nxt;
    ridx_r       <= ridx_nxt;
    best_r       <= best_nxt;
    cands_r      <= cands_nxt;
    only_r       <= only_nxt;
    pick_found_r <= pick_found_nxt;
    pick_r       <= pick_nxt;
    res_r        <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  // Zone table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      zone_mem[count_r[IDX_W-1:0]] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= zone_mem[addr_r[IDX_W-1:0]];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_r.found;
  assign out_zone_index = out_r.zone_index;
  assign out_status     = out_r.status;

endmodule

// ----- hdl/sample_zone_lookup_unit.sv -----
// Top level of the sample zone lookup block: configuration port and front/back wiring.
//
// Usage: requests enter on the in_ channel (valid/stall); each gives exactly one
// result on the out_ channel. Opcode load stores a zone in the next free slot
// (status 1 when all 16 are taken), clear empties the table, lookup picks the
// zone to play for a note and velocity (status 2 when none qualifies).
// The user must write map_mode through the APB-style cfg_ port only while the block
// is idle; the block itself does not enforce this. Front: a two-request queue
// decodes the opcode. Back: a sequencer walks the zone table through its registered
// read port, one entry per cycle. Load, clear and the unused opcode pass through the
// idle, execute and result states; an explicit-range lookup makes one pass over the
// zones held and a nearest-root lookup two. Requests are carried out one at a time,
// while the queue keeps accepting up to two more behind the running one.
// Reset empties the table and the queue and sets map_mode to explicit ranges;
// table contents are not cleared, only the zone count.
// When out_stall is high the result holds in the output register; the back
// end finishes its current request and waits, and in_stall rises once the
// queue is full.
module sample_zone_lookup_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [szl_pkg::NOTE_W-1:0]    in_note,
  input  logic [szl_pkg::VEL_W-1:0]     in_velocity,
  input  logic [szl_pkg::NOTE_W-1:0]    in_root_note,
  input  logic [szl_pkg::NOTE_W-1:0]    in_low_note,
  input  logic [szl_pkg::NOTE_W-1:0]    in_high_note,
  input  logic signed [szl_pkg::BOUND_W-1:0] in_low_velocity,
  input  logic signed [szl_pkg::BOUND_W-1:0] in_high_velocity,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [szl_pkg::OUT_IDX_W-1:0] out_zone_index,
  output logic [1:0]                    out_status,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic          map_mode_r, map_mode_nxt;
  logic          cfg_wr;
  logic          q_valid;
  logic          q_pop;
  szl_pkg::req_t q_req;

  // Register index is the word address; only index 0 exists.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    map_mode_nxt = map_mode_r;
    if (cfg_wr && cfg_paddr[2] == szl_pkg::REG_MAP_MODE) begin
      map_mode_nxt = cfg_pwdata[0];
    end
  end

  // Read back map_mode; addresses past the register list read zero.
  assign cfg_prdata = (cfg_paddr[2] == szl_pkg::REG_MAP_MODE) ? {31'b0, map_mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_mode_r <= 1'b0;
    end else begin
      map_mode_r <= map_mode_nxt;
    end
  end

  // Accept and classify requests.
  szl_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_note          (in_note),
    .in_velocity      (in_velocity),
    .in_root_note     (in_root_note),
    .in_low_note      (in_low_note),
    .in_high_note     (in_high_note),
    .in_low_velocity  (in_low_velocity),
    .in_high_velocity (in_high_velocity),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_req            (q_req)
  );

  // Carry out requests against the zone table and drive results.
  szl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .map_mode       (map_mode_r),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_req          (q_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_zone_index (out_zone_index),
    .out_status     (out_status)
  );

endmodule
